[sv/frustum_box_cull_unit_assert.svh]
// ----------------------------------------------------------------------------
// frustum_box_cull_unit_assert.svh
// Assertion macros for the frustum box cull unit. They compile to nothing
// when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef FRUSTUM_BOX_CULL_UNIT_ASSERT_SVH
`define FRUSTUM_BOX_CULL_UNIT_ASSERT_SVH

`ifndef SYNTH

// Same-cycle implication, disabled during reset
`define FBC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define FBC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define FBC_ASSERT_IMP(lbl, ante, cons, msg)
`define FBC_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

[sv/fbc_pkg.sv]
// ----------------------------------------------------------------------------
// fbc_pkg
// Shared widths and types of the frustum box cull unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fbc_pkg;

    // Matrix element and plane coefficient widths
    localparam int ELEM_W  = 32;
    localparam int COEF_W  = ELEM_W + 1;

    // Shared multiplier operands: coefficient (or its magnitude) times a 16-bit chunk
    localparam int MUL_A_W = COEF_W + 1;
    localparam int MUL_B_W = 17;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // Exact plane sum: six 65-bit products plus the offset term
    localparam int ACC_W   = 70;

    // Store addressing
    localparam int ADDR_W  = 4;
    localparam int DEPTH   = 16;

    // Per-cycle control of the multiply-accumulate unit
    typedef struct packed {
        logic clr;  // load accumulator with offset * 2^16
        logic en;   // operands valid this cycle
        logic hi;   // product weighs 2^16 (upper chunk)
    } t_mac_ctl;

endpackage

[sv/frustum_box_cull_unit.sv]
// ----------------------------------------------------------------------------
// frustum_box_cull_unit
// Box against view-frustum visibility test. Load items fill a 4x4 Q16.16
// matrix; test items are checked against the six planes built from it.
//
//  channel | handshake          | payload
//  --------+--------------------+-------------------------------------------
//  input   | i_valid / o_ready  | operation, elem_index/value, center, half
//  output  | o_valid / i_ready  | visible (test items only)
//
//  A load item is written to the store; the block stays ready.
//  A test item holds the block while each of the six planes runs through store
//  reads, an accumulator clear, multiplies on the shared 34x17 multiplier and a
//  pipeline drain; a final state then posts the result.
//  A pending result does not block the next item; a later test waits in its
//  final cycle until the output register is free.
//  Reset is synchronous and clears the matrix store to zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "frustum_box_cull_unit_assert.svh"

module frustum_box_cull_unit
    import fbc_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic                     i_operation,
    input  logic [ADDR_W-1:0]        i_elem_index,
    input  logic signed [ELEM_W-1:0] i_elem_value,
    input  logic signed [31:0]       i_center_x,
    input  logic signed [31:0]       i_center_y,
    input  logic signed [31:0]       i_center_z,
    input  logic [30:0]              i_half_x,
    input  logic [30:0]              i_half_y,
    input  logic [30:0]              i_half_z,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic                     o_visible
);

    // Sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RD    = 3'd1;
    localparam logic [2:0] S_CLR   = 3'd2;
    localparam logic [2:0] S_MUL   = 3'd3;
    localparam logic [2:0] S_DRAIN = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    localparam logic [3:0] RD_LAST    = 4'd4;
    localparam logic [3:0] MUL_LAST   = 4'd11;
    localparam logic [3:0] DRAIN_LAST = 4'd1;
    localparam logic [2:0] PLANE_LAST = 3'd5;
    localparam logic       OP_LOAD    = 1'b0;

    logic [2:0]               r_state, n_state;
    logic [3:0]               r_step, n_step;
    logic [2:0]               r_plane, n_plane;
    logic                     r_vis, n_vis;
    logic                     r_out_valid, n_out_valid;
    logic                     r_out_vis, n_out_vis;
    logic signed [31:0]       r_cx, r_cy, r_cz;
    logic [30:0]              r_hx, r_hy, r_hz;
    logic signed [COEF_W-1:0] r_nx, r_ny, r_nz, r_w;

    logic                     in_acc;
    logic                     store_wr;
    logic [ADDR_W-1:0]        rd_addr_a, rd_addr_b;
    logic [ELEM_W-1:0]        rd_data_a, rd_data_b;
    logic signed [COEF_W-1:0] coef_a, coef_b, coef_new;
    logic                     coef_shift;

    t_mac_ctl                 mac_ctl;
    logic signed [COEF_W-1:0]  n_sel;
    logic signed [31:0]        c_sel;
    logic [30:0]               h_sel;
    logic signed [MUL_A_W-1:0] n_ext, n_abs;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic                      acc_neg;
    logic                      plane_cull;

    assign o_ready   = (r_state == S_IDLE);
    assign in_acc    = i_valid && o_ready;
    assign store_wr  = in_acc && (i_operation == OP_LOAD);
    assign o_valid   = r_out_valid;
    assign o_visible = r_out_vis;

    // Store reads: column r_step, row 3 and the plane's row
    assign rd_addr_a = {r_step[1:0], 2'b11};
    assign rd_addr_b = {r_step[1:0], r_plane[2:1]};

    fbc_matrix_store u_store (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr_en     (store_wr),
        .i_wr_addr   (i_elem_index),
        .i_wr_data   (i_elem_value),
        .i_rd_addr_a (rd_addr_a),
        .i_rd_addr_b (rd_addr_b),
        .o_rd_data_a (rd_data_a),
        .o_rd_data_b (rd_data_b)
    );

    // Plane coefficient: row3 plus or minus the selected row
    assign coef_a     = {rd_data_a[ELEM_W-1], rd_data_a};
    assign coef_b     = {rd_data_b[ELEM_W-1], rd_data_b};
    assign coef_new   = r_plane[0] ? (coef_a - coef_b) : (coef_a + coef_b);
    assign coef_shift = (r_state == S_RD) && (r_step != 4'd0);

    // Operand select: axis from step[3:2], term from step[1:0]
    always_comb begin
        case (r_step[3:2])
            2'd0:    begin n_sel = r_nx; c_sel = r_cx; h_sel = r_hx; end
            2'd1:    begin n_sel = r_ny; c_sel = r_cy; h_sel = r_hy; end
            default: begin n_sel = r_nz; c_sel = r_cz; h_sel = r_hz; end
        endcase
    end

    assign n_ext = {n_sel[COEF_W-1], n_sel};
    assign n_abs = n_ext[MUL_A_W-1] ? -n_ext : n_ext;

    always_comb begin
        mac_ctl.clr = (r_state == S_CLR);
        mac_ctl.en  = (r_state == S_MUL);
        case (r_step[1:0])
            2'd0: begin
                mul_a = n_ext;
                mul_b = {1'b0, c_sel[15:0]};
                mac_ctl.hi = 1'b0;
            end
            2'd1: begin
                mul_a = n_ext;
                mul_b = {c_sel[31], c_sel[31:16]};
                mac_ctl.hi = 1'b1;
            end
            2'd2: begin
                mul_a = n_abs;
                mul_b = {1'b0, h_sel[15:0]};
                mac_ctl.hi = 1'b0;
            end
            default: begin
                mul_a = n_abs;
                mul_b = {2'b00, h_sel[30:16]};
                mac_ctl.hi = 1'b1;
            end
        endcase
    end

    fbc_mac u_mac (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (mac_ctl),
        .i_init    (r_w),
        .i_mul_a   (mul_a),
        .i_mul_b   (mul_b),
        .o_acc_neg (acc_neg)
    );

    // A plane with a zero normal never culls
    assign plane_cull = acc_neg && ((r_nx != '0) || (r_ny != '0) || (r_nz != '0));

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_plane     = r_plane;
        n_vis       = r_vis;
        n_out_valid = r_out_valid && !i_ready;
        n_out_vis   = r_out_vis;
        case (r_state)
            S_IDLE: begin
                if (in_acc && (i_operation != OP_LOAD)) begin
                    n_state = S_RD;
                    n_step  = '0;
                    n_plane = '0;
                    n_vis   = 1'b1;
                end
            end
            S_RD: begin
                if (r_step == RD_LAST) begin
                    n_state = S_CLR;
                    n_step  = '0;
                end else begin
                    n_step = r_step + 4'd1;
                end
            end
            S_CLR: begin
                n_state = S_MUL;
                n_step  = '0;
            end
            S_MUL: begin
                if (r_step == MUL_LAST) begin
                    n_state = S_DRAIN;
                    n_step  = '0;
                end else begin
                    n_step = r_step + 4'd1;
                end
            end
            S_DRAIN: begin
                if (r_step == DRAIN_LAST) begin
                    n_vis  = r_vis && !plane_cull;
                    n_step = '0;
                    if (r_plane == PLANE_LAST) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_RD;
                        n_plane = r_plane + 3'd1;
                    end
                end else begin
                    n_step = r_step + 4'd1;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid = 1'b1;
                    n_out_vis   = r_vis;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_plane     <= '0;
            r_vis       <= 1'b1;
            r_out_valid <= 1'b0;
            r_out_vis   <= 1'b1;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_plane     <= n_plane;
            r_vis       <= n_vis;
            r_out_valid <= n_out_valid;
            r_out_vis   <= n_out_vis;
        end
    end

    // Box operands, held for the whole test
    always_ff @(posedge i_clk) begin
        if (in_acc && (i_operation != OP_LOAD)) begin
            r_cx <= i_center_x;
            r_cy <= i_center_y;
            r_cz <= i_center_z;
            r_hx <= i_half_x;
            r_hy <= i_half_y;
            r_hz <= i_half_z;
        end
    end

    // Plane coefficients shift in x, y, z, then w
    always_ff @(posedge i_clk) begin
        if (coef_shift) begin
            r_nx <= r_ny;
            r_ny <= r_nz;
            r_nz <= r_w;
            r_w  <= coef_new;
        end
    end

    // Assertions
    `FBC_ASSERT_NXT(a_test_starts, in_acc && (i_operation != OP_LOAD), (r_state == S_RD) && (r_plane == 3'd0) && (r_step == 4'd0) && r_vis, "test item did not start at plane 0")
    `FBC_ASSERT_NXT(a_load_stays_idle, store_wr, (r_state == S_IDLE) && o_ready, "load item left the idle state")
    `FBC_ASSERT_IMP(a_plane_range, r_state != S_IDLE, r_plane <= PLANE_LAST, "plane counter out of range")
    `FBC_ASSERT_IMP(a_mul_step_range, r_state == S_MUL, r_step <= MUL_LAST, "multiply step out of range")

endmodule

[sv/fbc_matrix_store.sv]
// ----------------------------------------------------------------------------
// fbc_matrix_store
// 16 x 32 matrix store, one write port and two registered read ports.
// Per-entry valid bits make unwritten entries read as zero after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fbc_matrix_store
    import fbc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [ELEM_W-1:0] i_wr_data,
    input  logic [ADDR_W-1:0] i_rd_addr_a,
    input  logic [ADDR_W-1:0] i_rd_addr_b,
    output logic [ELEM_W-1:0] o_rd_data_a,
    output logic [ELEM_W-1:0] o_rd_data_b
);

    logic [ELEM_W-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0]  r_valid;
    logic [ELEM_W-1:0] r_rd_a;
    logic [ELEM_W-1:0] r_rd_b;

    // Valid bits, cleared by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr_en) begin
            r_valid[i_wr_addr] <= 1'b1;
        end
    end

    // Array write
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered reads; an unwritten entry reads as zero
    always_ff @(posedge i_clk) begin
        r_rd_a <= r_valid[i_rd_addr_a] ? r_mem[i_rd_addr_a] : '0;
        r_rd_b <= r_valid[i_rd_addr_b] ? r_mem[i_rd_addr_b] : '0;
    end

    assign o_rd_data_a = r_rd_a;
    assign o_rd_data_b = r_rd_b;

endmodule

[sv/fbc_mac.sv]
// ----------------------------------------------------------------------------
// fbc_mac
// Shared 34x17 signed multiplier with a registered product and an exact
// 70-bit accumulator. Reports the sign of the running plane sum.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fbc_mac
    import fbc_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_mac_ctl                  i_ctl,
    input  logic signed [COEF_W-1:0]  i_init,
    input  logic signed [MUL_A_W-1:0] i_mul_a,
    input  logic signed [MUL_B_W-1:0] i_mul_b,
    output logic                      o_acc_neg
);

    localparam int HI_W = PROD_W + 16;

    logic signed [PROD_W-1:0] r_prod;
    logic                     r_prod_vld;
    logic                     r_prod_hi;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W-1:0]  prod_ext;

    // Product stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_vld <= 1'b0;
        end else begin
            r_prod_vld <= i_ctl.en;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod    <= i_mul_a * i_mul_b;
        r_prod_hi <= i_ctl.hi;
    end

    // Align the product to the Q.32 accumulator
    always_comb begin
        if (r_prod_hi) begin
            prod_ext = {{(ACC_W-HI_W){r_prod[PROD_W-1]}}, r_prod, 16'h0000};
        end else begin
            prod_ext = {{(ACC_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};
        end
    end

    // Accumulator: offset term on clear, then one product per cycle while r_prod_vld is set
    always_ff @(posedge i_clk) begin
        if (i_ctl.clr) begin
            r_acc <= {{(ACC_W-COEF_W-16){i_init[COEF_W-1]}}, i_init, 16'h0000};
        end else if (r_prod_vld) begin
            r_acc <= r_acc + prod_ext;
        end
    end

    assign o_acc_neg = r_acc[ACC_W-1];

endmodule
